// ===== hdl/ssel_pkg.sv =====
// Shared types, constants and control bundles for the spaced site selector.
`default_nettype none
package ssel_pkg;

  localparam int MAX_SITES = 64;
  localparam int IDX_W     = $clog2(MAX_SITES);
  localparam int CNT_W     = $clog2(MAX_SITES + 1);
  localparam int POS_W     = 16;
  localparam int REV_W     = 16;
  localparam int GAIN_W    = 22;
  localparam int GAP_W     = 16;

  localparam logic [GAP_W-1:0] GAP_RESET   = 16'd5;
  localparam logic             REG_MIN_GAP = 1'b0;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [REV_W-1:0] revenue;
    logic             last;
  } ssel_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  chosen_position;
    logic [GAIN_W-1:0] total_gain;
    logic              end_of_run;
  } ssel_out_t;

  // Read address source for the site tables
  typedef enum logic [1:0] {
    RD_I = 2'd0,
    RD_J = 2'd1,
    RD_P = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_wr;
    logic    start;
    rd_sel_t rd_sel;
    logic    cap_site;
    logic    set_p;
    logic    clr_p;
    logic    j_dec;
    logic    cap_base;
    logic    wr_site;
    logic    i_inc;
    logic    fin;
    logic    tb_take;
    logic    tb_skip;
    logic    out_load;
    logic    out_empty;
  } ssel_cmd_t;

  typedef struct packed {
    logic close;
    logic i_zero;
    logic j_one;
    logic gap_ok;
    logic i_last;
    logic best_zero;
    logic taken;
    logic is_end;
    logic out_free;
  } ssel_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ssel_dp.sv =====
// Datapath: site tables, search counters, dynamic programming values, output register.
`default_nettype none
module ssel_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ssel_pkg::ssel_in_t          in_data,
  input  wire logic [ssel_pkg::GAP_W-1:0]  min_gap,
  input  wire ssel_pkg::ssel_cmd_t         cmd,
  output ssel_pkg::ssel_stat_t             stat,
  output ssel_pkg::ssel_out_t              out_data,
  output logic                             out_valid,
  input  wire logic                        out_ready
);

  // Site tables
  logic [ssel_pkg::POS_W-1:0]  pos_mem     [ssel_pkg::MAX_SITES];
  logic [ssel_pkg::REV_W-1:0]  rev_mem     [ssel_pkg::MAX_SITES];
  logic [ssel_pkg::GAIN_W-1:0] with_mem    [ssel_pkg::MAX_SITES];
  logic [ssel_pkg::GAIN_W-1:0] without_mem [ssel_pkg::MAX_SITES];
  logic [ssel_pkg::CNT_W-1:0]  pred_mem    [ssel_pkg::MAX_SITES];

  logic [ssel_pkg::POS_W-1:0]  pos_rd_r;
  logic [ssel_pkg::REV_W-1:0]  rev_rd_r;
  logic [ssel_pkg::GAIN_W-1:0] with_rd_r;
  logic [ssel_pkg::GAIN_W-1:0] without_rd_r;
  logic [ssel_pkg::CNT_W-1:0]  pred_rd_r;

  // Counters and working values
  logic [ssel_pkg::CNT_W-1:0]  count_r;
  logic [ssel_pkg::CNT_W-1:0]  n_r;
  logic [ssel_pkg::IDX_W-1:0]  i_r;
  logic [ssel_pkg::CNT_W-1:0]  j_r;
  logic [ssel_pkg::CNT_W-1:0]  p_r;
  logic [ssel_pkg::POS_W-1:0]  pos_i_r;
  logic [ssel_pkg::REV_W-1:0]  rev_i_r;
  logic [ssel_pkg::GAIN_W-1:0] base_r;
  logic [ssel_pkg::GAIN_W-1:0] prev_best_r;
  logic [ssel_pkg::GAIN_W-1:0] total_r;
  logic                        out_valid_r;
  ssel_pkg::ssel_out_t         out_r;

  logic [ssel_pkg::CNT_W-1:0]  j_m1;
  logic [ssel_pkg::CNT_W-1:0]  p_m1;
  logic [ssel_pkg::CNT_W-1:0]  n_m1;
  logic [ssel_pkg::IDX_W-1:0]  rd_addr;
  logic [ssel_pkg::POS_W:0]    gap_diff;
  logic [ssel_pkg::GAIN_W-1:0] with_new;
  logic [ssel_pkg::GAIN_W-1:0] best_nxt;
  logic [ssel_pkg::GAIN_W-1:0] base_nxt;

  assign j_m1 = j_r - ssel_pkg::CNT_W'(1);
  assign p_m1 = p_r - ssel_pkg::CNT_W'(1);
  assign n_m1 = n_r - ssel_pkg::CNT_W'(1);

  // Select the table read address
  always_comb begin
    case (cmd.rd_sel)
      ssel_pkg::RD_I: rd_addr = i_r;
      ssel_pkg::RD_J: rd_addr = j_m1[ssel_pkg::IDX_W-1:0];
      ssel_pkg::RD_P: rd_addr = p_m1[ssel_pkg::IDX_W-1:0];
      default:        rd_addr = i_r;
    endcase
  end

  // Signed distance from the current site to the candidate
  assign gap_diff = {1'b0, pos_i_r} - {1'b0, pos_rd_r};
  assign with_new = base_r + ssel_pkg::GAIN_W'(rev_i_r);
  assign best_nxt = (with_new > prev_best_r) ? with_new : prev_best_r;
  assign base_nxt = (with_rd_r > without_rd_r) ? with_rd_r : without_rd_r;

  // Position and revenue tables, written while loading
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      pos_mem[count_r[ssel_pkg::IDX_W-1:0]] <= in_data.position;
      rev_mem[count_r[ssel_pkg::IDX_W-1:0]] <= in_data.revenue;
    end
    pos_rd_r <= pos_mem[rd_addr];
    rev_rd_r <= rev_mem[rd_addr];
  end

  // Per-site results, written once per site
  always_ff @(posedge clk) begin
    if (cmd.wr_site) begin
      with_mem[i_r]    <= with_new;
      without_mem[i_r] <= prev_best_r;
      pred_mem[i_r]    <= p_r;
    end
    with_rd_r    <= with_mem[rd_addr];
    without_rd_r <= without_mem[rd_addr];
    pred_rd_r    <= pred_mem[rd_addr];
  end

  // Control counters and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_wr) begin
        count_r <= stat.close ? '0 : count_r + ssel_pkg::CNT_W'(1);
      end
      if (cmd.out_load || cmd.out_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the search and traceback
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r         <= count_r + ssel_pkg::CNT_W'(1);
      i_r         <= '0;
      prev_best_r <= '0;
    end
    if (cmd.cap_site) begin
      pos_i_r <= pos_rd_r;
      rev_i_r <= rev_rd_r;
      j_r     <= ssel_pkg::CNT_W'(i_r);
    end
    if (cmd.j_dec || cmd.tb_skip) begin
      j_r <= j_m1;
    end
    if (cmd.set_p) begin
      p_r <= j_r;
    end
    if (cmd.clr_p) begin
      p_r    <= '0;
      base_r <= '0;
    end
    if (cmd.cap_base) begin
      base_r <= base_nxt;
    end
    if (cmd.wr_site) begin
      prev_best_r <= best_nxt;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + ssel_pkg::IDX_W'(1);
    end
    if (cmd.fin) begin
      total_r <= best_nxt;
      j_r     <= n_r;
    end
    if (cmd.tb_take) begin
      j_r <= pred_rd_r;
    end
    if (cmd.out_load) begin
      out_r.chosen_position <= pos_rd_r;
      out_r.total_gain      <= total_r;
      out_r.end_of_run      <= stat.is_end;
    end else if (cmd.out_empty) begin
      out_r.chosen_position <= '0;
      out_r.total_gain      <= '0;
      out_r.end_of_run      <= 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    stat.close     = in_data.last
                     || (count_r == ssel_pkg::CNT_W'(ssel_pkg::MAX_SITES - 1));
    stat.i_zero    = (i_r == '0);
    stat.j_one     = (j_r == ssel_pkg::CNT_W'(1));
    stat.gap_ok    = !gap_diff[ssel_pkg::POS_W]
                     && (gap_diff[ssel_pkg::POS_W-1:0] >= min_gap);
    stat.i_last    = (ssel_pkg::CNT_W'(i_r) == n_m1);
    stat.best_zero = (best_nxt == '0);
    stat.taken     = (with_rd_r > without_rd_r);
    // no earlier value left under this site: it is the first chosen one
    stat.is_end    = (with_rd_r == ssel_pkg::GAIN_W'(rev_rd_r));
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hdl/ssel_ctrl.sv =====
// Controller: sequences loading, the per-site search, the table fill and the traceback.
`default_nettype none
module ssel_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ssel_pkg::ssel_stat_t stat,
  output ssel_pkg::ssel_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_C_RD,
    ST_C_CAP,
    ST_S_RD,
    ST_S_EV,
    ST_B_RD,
    ST_B_EV,
    ST_C_WR,
    ST_T_RD,
    ST_T_EV,
    ST_EMPTY
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands and the next state
  always_comb begin
    cmd       = '0;
    cmd.rd_sel = ssel_pkg::RD_I;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.load_wr = in_valid;
        if (in_valid && stat.close) begin
          cmd.start = 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_C_RD: begin
        cmd.rd_sel = ssel_pkg::RD_I;
        state_nxt  = ST_C_CAP;
      end
      ST_C_CAP: begin
        cmd.cap_site = 1'b1;
        if (stat.i_zero) begin
          cmd.clr_p = 1'b1;
          state_nxt = ST_C_WR;
        end else begin
          state_nxt = ST_S_RD;
        end
      end
      ST_S_RD: begin
        cmd.rd_sel = ssel_pkg::RD_J;
        state_nxt  = ST_S_EV;
      end
      ST_S_EV: begin
        cmd.rd_sel = ssel_pkg::RD_J;
        if (stat.gap_ok) begin
          cmd.set_p = 1'b1;
          state_nxt = ST_B_RD;
        end else if (stat.j_one) begin
          cmd.clr_p = 1'b1;
          state_nxt = ST_C_WR;
        end else begin
          cmd.j_dec = 1'b1;
          state_nxt = ST_S_RD;
        end
      end
      ST_B_RD: begin
        cmd.rd_sel = ssel_pkg::RD_P;
        state_nxt  = ST_B_EV;
      end
      ST_B_EV: begin
        cmd.rd_sel   = ssel_pkg::RD_P;
        cmd.cap_base = 1'b1;
        state_nxt    = ST_C_WR;
      end
      ST_C_WR: begin
        cmd.wr_site = 1'b1;
        if (stat.i_last) begin
          cmd.fin   = 1'b1;
          state_nxt = stat.best_zero ? ST_EMPTY : ST_T_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_T_RD: begin
        cmd.rd_sel = ssel_pkg::RD_J;
        state_nxt  = ST_T_EV;
      end
      ST_T_EV: begin
        cmd.rd_sel = ssel_pkg::RD_J;
        if (!stat.taken) begin
          cmd.tb_skip = 1'b1;
          state_nxt   = ST_T_RD;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.is_end) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.tb_take = 1'b1;
            state_nxt   = ST_T_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.out_empty = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spaced_site_selection_dp.sv =====
// Loading: one item per cycle in ST_LOAD; the item with last set (or the 64th) closes
// the set. Fill, per site: read and capture it, search back over the position table
// (read, evaluate per step), read and evaluate a found predecessor, write; traceback
// reads and evaluates per visited site, plus any output stall; one read port sets this.
// Reset: min_gap returns to 5 and the site store is empty; the tables need no clearing.
`default_nettype none
module spaced_site_selection_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ssel_pkg::ssel_in_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ssel_pkg::ssel_out_t             out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  ssel_pkg::ssel_cmd_t         cmd;
  ssel_pkg::ssel_stat_t        stat;
  logic [ssel_pkg::GAP_W-1:0]  min_gap_r;
  logic                        gap_sel;

  // Register decode
  assign gap_sel = (paddr[2] == ssel_pkg::REG_MIN_GAP);
  assign pready  = 1'b1;
  assign prdata  = gap_sel ? {{(32 - ssel_pkg::GAP_W){1'b0}}, min_gap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= ssel_pkg::GAP_RESET;
    end else if (psel && penable && pwrite && pready && gap_sel) begin
      min_gap_r <= pwdata[ssel_pkg::GAP_W-1:0];
    end
  end

  ssel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssel_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .min_gap   (min_gap_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // A zero total only comes as the single empty-selection item
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.total_gain == '0)
      |-> (out_data.end_of_run && out_data.chosen_position == '0))
    else $error("zero total on a non-empty answer item");

  // Inside an answer the input side stays closed
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.end_of_run) |-> !in_ready)
    else $error("input open while an answer is still being traced");

  // Nothing is loaded into the output while it still holds an untaken item
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(cmd.out_load || cmd.out_empty))
    else $error("output register overwritten before it was taken");

endmodule
`default_nettype wire
